>>> rtl/core/exl_pkg.sv
// Shared types, character codes and token helpers for the expression lexer.
package exl_pkg;

	localparam int MAX_PUSH   = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5a;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7a;
	localparam logic [7:0] CH_UNDER  = 8'h5f;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_BAR    = 8'h7c;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	// Keywords packed with the first character in the low byte.
	localparam logic [63:0] KW_INT   = 64'h0000_0000_0074_6e69;
	localparam logic [63:0] KW_BOOL  = 64'h0000_0000_6c6f_6f62;
	localparam logic [63:0] KW_IF    = 64'h0000_0000_0000_6669;
	localparam logic [63:0] KW_ELSE  = 64'h0000_0000_6573_6c65;
	localparam logic [63:0] KW_TRUE  = 64'h0000_0000_6575_7274;
	localparam logic [63:0] KW_FALSE = 64'h0000_0065_736c_6166;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUMBER,
		MODE_NAME,
		MODE_HOLD
	} lex_mode_t;

	typedef enum logic [4:0] {
		TK_INTLIT, TK_BOOL, TK_INT, TK_IF, TK_ELSE, TK_IDENT, TK_TRUE, TK_FALSE,
		TK_SEMI, TK_NOT, TK_OR, TK_AND, TK_RBRACE, TK_LBRACE, TK_EQEQ, TK_EQ,
		TK_LE, TK_GE, TK_LT, TK_GT, TK_MUL, TK_DIV, TK_PLUS, TK_MINUS,
		TK_LPAREN, TK_RPAREN, TK_END
	} tok_kind_t;

	typedef struct packed {
		lex_mode_t   mode;
		logic [7:0]  held;
		logic [31:0] accum;
		logic        neg;
		logic        clamp;
		logic [63:0] name_buf;
		logic [3:0]  name_cnt;
		logic        name_ovf;
	} lex_state_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [31:0] value;
		logic        sat;
		logic [63:0] packed_name;
		logic [3:0]  len;
		logic        trunc;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0]  n;
		tok_t [2:0]  tok;
	} push_t;

	function automatic lex_state_t clear_state();
		lex_state_t s;
		s = '0;
		s.mode = MODE_IDLE;
		return s;
	endfunction

	function automatic tok_t plain_tok(tok_kind_t k);
		tok_t t;
		t = '0;
		t.kind = k;
		return t;
	endfunction

	// Token that the pending state turns into when it is ended; vld is low
	// when nothing is pending or when a lone & or | is held.
	function automatic tok_t pending_tok(lex_state_t s, output logic vld);
		tok_t t;
		t = '0;
		vld = 1'b1;
		case (s.mode)
			MODE_NUMBER: begin
				t.kind = TK_INTLIT;
				t.value = s.neg ? (32'd0 - s.accum) : s.accum;
				t.sat = s.clamp;
			end
			MODE_NAME: begin
				t.kind = TK_IDENT;
				t.packed_name = s.name_buf;
				t.len = s.name_cnt;
				t.trunc = s.name_ovf;
				if (!s.name_ovf) begin
					if (s.name_cnt == 4'd3 && s.name_buf == KW_INT) t = plain_tok(TK_INT);
					else if (s.name_cnt == 4'd4 && s.name_buf == KW_BOOL) t = plain_tok(TK_BOOL);
					else if (s.name_cnt == 4'd2 && s.name_buf == KW_IF) t = plain_tok(TK_IF);
					else if (s.name_cnt == 4'd4 && s.name_buf == KW_ELSE) t = plain_tok(TK_ELSE);
					else if (s.name_cnt == 4'd4 && s.name_buf == KW_TRUE) begin
						t = plain_tok(TK_TRUE);
						t.value = 32'd1;
					end
					else if (s.name_cnt == 4'd5 && s.name_buf == KW_FALSE) t = plain_tok(TK_FALSE);
				end
			end
			MODE_HOLD: begin
				case (s.held)
					CH_EQ:    t.kind = TK_EQ;
					CH_LT:    t.kind = TK_LT;
					CH_GT:    t.kind = TK_GT;
					CH_MINUS: t.kind = TK_MINUS;
					default:  vld = 1'b0;
				endcase
			end
			default: vld = 1'b0;
		endcase
		return t;
	endfunction

endpackage

>>> rtl/core/exl_core.sv
// Input register, lexer state register and the per-character step logic.
module exl_core import exl_pkg::*; #(
	parameter int MAX_NAME_CHARS = 8,
	parameter int VALUE_BITS     = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	input  logic       room,
	output push_t      push
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        eot_s1;
	lex_state_t  state_q;
	lex_state_t  st;
	logic        fire;

	logic        is_digit, is_name;
	logic [3:0]  digit;
	logic [35:0] prod, lim;
	tok_t        tok_a, tok_b, tok_c, tok_a_p, tok_c_p;
	logic        vld_a, vld_b, vld_c, vld_a_p, vld_c_p;
	logic        go_new;
	tok_t [3:0]  cand;
	logic [3:0]  cand_vld;
	logic [2:0]  n;

	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
			eot_s1  <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clear_state();
		end else if (fire) begin
			state_q <= st;
		end
	end

	assign is_digit = char_s1 inside {[CH_0:CH_9]};
	assign is_name  = (char_s1 inside {[CH_LA:CH_LZ]}) || (char_s1 inside {[CH_UA:CH_UZ]}) ||
		(char_s1 == CH_UNDER);
	assign digit    = 4'(char_s1 - CH_0);

	// Next magnitude is accum * 10 + digit, clamped at the signed limit.
	assign prod = ({4'd0, state_q.accum} << 3) + ({4'd0, state_q.accum} << 1) + {32'd0, digit};
	assign lim  = (36'd1 << (VALUE_BITS - 1)) - {35'd0, ~state_q.neg};

	always_comb begin
		tok_a_p = pending_tok(state_q, vld_a_p);
	end

	always_comb begin
		st     = state_q;
		tok_a  = '0;
		vld_a  = 1'b0;
		tok_b  = '0;
		vld_b  = 1'b0;
		go_new = 1'b0;
		case (state_q.mode)
			MODE_NUMBER: begin
				if (is_digit) begin
					if (prod > lim) begin
						st.accum = lim[31:0];
						st.clamp = 1'b1;
					end else begin
						st.accum = prod[31:0];
					end
				end else begin
					tok_a  = tok_a_p;
					vld_a  = vld_a_p;
					st     = clear_state();
					go_new = 1'b1;
				end
			end
			MODE_NAME: begin
				if (is_digit || is_name) begin
					if (state_q.name_cnt < 4'(MAX_NAME_CHARS)) begin
						for (int i = 0; i < 8; i++) begin
							if (state_q.name_cnt[2:0] == 3'(i)) st.name_buf[8*i +: 8] = char_s1;
						end
						st.name_cnt = state_q.name_cnt + 4'd1;
					end else begin
						st.name_ovf = 1'b1;
					end
				end else begin
					tok_a  = tok_a_p;
					vld_a  = vld_a_p;
					st     = clear_state();
					go_new = 1'b1;
				end
			end
			MODE_HOLD: begin
				st = clear_state();
				if (state_q.held == CH_EQ && char_s1 == CH_EQ) begin
					tok_b = plain_tok(TK_EQEQ);
					vld_b = 1'b1;
				end else if (state_q.held == CH_LT && char_s1 == CH_EQ) begin
					tok_b = plain_tok(TK_LE);
					vld_b = 1'b1;
				end else if (state_q.held == CH_GT && char_s1 == CH_EQ) begin
					tok_b = plain_tok(TK_GE);
					vld_b = 1'b1;
				end else if (state_q.held == CH_AMP && char_s1 == CH_AMP) begin
					tok_b = plain_tok(TK_AND);
					vld_b = 1'b1;
				end else if (state_q.held == CH_BAR && char_s1 == CH_BAR) begin
					tok_b = plain_tok(TK_OR);
					vld_b = 1'b1;
				end else if (state_q.held == CH_MINUS && is_digit) begin
					st.mode  = MODE_NUMBER;
					st.accum = {28'd0, digit};
					st.neg   = 1'b1;
				end else begin
					tok_a  = tok_a_p;
					vld_a  = vld_a_p;
					go_new = 1'b1;
				end
			end
			default: begin
				st.mode = MODE_IDLE;
				go_new  = 1'b1;
			end
		endcase

		if (go_new) begin
			if (is_digit) begin
				st.mode  = MODE_NUMBER;
				st.accum = {28'd0, digit};
				st.neg   = 1'b0;
				st.clamp = 1'b0;
			end else if (is_name) begin
				st.mode     = MODE_NAME;
				st.name_buf = {56'd0, char_s1};
				st.name_cnt = 4'd1;
				st.name_ovf = 1'b0;
			end else begin
				case (char_s1)
					CH_EQ, CH_LT, CH_GT, CH_AMP, CH_BAR, CH_MINUS: begin
						st.mode = MODE_HOLD;
						st.held = char_s1;
					end
					CH_SEMI: begin
						tok_b = plain_tok(TK_SEMI);
						vld_b = 1'b1;
					end
					CH_BANG: begin
						tok_b = plain_tok(TK_NOT);
						vld_b = 1'b1;
					end
					CH_RBRACE: begin
						tok_b = plain_tok(TK_RBRACE);
						vld_b = 1'b1;
					end
					CH_LBRACE: begin
						tok_b = plain_tok(TK_LBRACE);
						vld_b = 1'b1;
					end
					CH_STAR: begin
						tok_b = plain_tok(TK_MUL);
						vld_b = 1'b1;
					end
					CH_SLASH: begin
						tok_b = plain_tok(TK_DIV);
						vld_b = 1'b1;
					end
					CH_PLUS: begin
						tok_b = plain_tok(TK_PLUS);
						vld_b = 1'b1;
					end
					CH_LPAREN: begin
						tok_b = plain_tok(TK_LPAREN);
						vld_b = 1'b1;
					end
					CH_RPAREN: begin
						tok_b = plain_tok(TK_RPAREN);
						vld_b = 1'b1;
					end
					default: ;
				endcase
			end
		end

		tok_c_p = pending_tok(st, vld_c_p);
		tok_c   = tok_c_p;
		vld_c   = vld_c_p && eot_s1;
		if (eot_s1) st = clear_state();
	end

	// Pack the up to three tokens of this character in emission order.
	always_comb begin
		cand     = {plain_tok(TK_END), tok_c, tok_b, tok_a};
		cand_vld = {eot_s1, vld_c, vld_b, vld_a};
		push     = '0;
		n        = 3'd0;
		for (int i = 0; i < 4; i++) begin
			if (cand_vld[i] && n < 3'(MAX_PUSH)) begin
				push.tok[n[1:0]] = cand[i];
				n = n + 3'd1;
			end
		end
		if (n != 3'd0) push.tok[2'(n - 3'd1)].last = 1'b1;
		push.n = fire ? n[1:0] : 2'd0;
	end

endmodule

>>> rtl/core/exl_tok_fifo.sv
// Token queue that takes up to three tokens a cycle and hands out one while out_stall is low.
module exl_tok_fifo import exl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  push_t push,
	output logic room,
	output logic out_valid,
	input  logic out_stall,
	output tok_t head_tok
);

	tok_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	assign room      = count_q <= CNT_W'(FIFO_DEPTH - MAX_PUSH);
	assign head_tok  = mem_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + PTR_W'(push.n);
			head_q  <= head_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_PUSH; i++) begin
			if (2'(i) < push.n) mem_q[tail_q + PTR_W'(i)] <= push.tok[i];
		end
	end

endmodule

>>> rtl/core/expression_language_lexer_top.sv
// Top level of the streaming expression lexer: character in, tokens out.
// An accepted character is registered; its tokens pass through the token queue.
// One character is taken per cycle while in_stall is low and each yields up to three
// tokens; a character that yields several tokens sends them one by one on the
// single output port, and the four-entry token queue absorbs such bursts.
// Reset clears the lexer state, the input valid flag and the token queue.
module expression_language_lexer_top import exl_pkg::*; #(
	parameter int MAX_NAME_CHARS = 8,
	parameter int VALUE_BITS     = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               end_of_text,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         token_kind,
	output logic signed [31:0] literal_value,
	output logic               value_saturated,
	output logic [63:0]        name_packed,
	output logic [3:0]         name_length,
	output logic               name_truncated,
	output logic               last_of_run
);

	push_t push;
	logic  room;
	tok_t  head_tok;

	exl_core #(
		.MAX_NAME_CHARS(MAX_NAME_CHARS),
		.VALUE_BITS(VALUE_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.end_of_text(end_of_text),
		.room(room),
		.push(push)
	);

	exl_tok_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head_tok(head_tok)
	);

	assign token_kind      = head_tok.kind;
	assign literal_value   = $signed(head_tok.value);
	assign value_saturated = head_tok.sat;
	assign name_packed     = head_tok.packed_name;
	assign name_length     = head_tok.len;
	assign name_truncated  = head_tok.trunc;
	assign last_of_run     = head_tok.last;

endmodule
